// ===== rtl/core/setc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setc_pkg
// Shared types and constants for the scope edge trigger capture core.
// ----------------------------------------------------------------------------
package setc_pkg;

	localparam int LEVEL_BITS   = 12;
	localparam int FIELD_BITS   = 12;
	localparam int TIME_BITS    = 32;
	localparam int HOLDOFF_BITS = 16;
	localparam int INDEX_BITS   = 7;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DAT_BITS = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEVEL   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RISING  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLDOFF = 2'd2;

	// request opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// configuration reset values
	localparam logic [LEVEL_BITS-1:0]   LEVEL_RST   = 12'd2109;
	localparam logic                    RISING_RST  = 1'b0;
	localparam logic [HOLDOFF_BITS-1:0] HOLDOFF_RST = 16'd300;

	typedef struct packed {
		logic                  op;
		logic [FIELD_BITS-1:0] sample;
		logic [TIME_BITS-1:0]  time_ms;
		logic [INDEX_BITS-1:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic                  trigger_fired;
		logic                  captured;
		logic [INDEX_BITS-1:0] write_index;
		logic [FIELD_BITS-1:0] floor_level;
		logic [FIELD_BITS-1:0] read_value;
	} out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/setc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setc_in_if
// Request channel: sample and read requests with valid/ready.
// ----------------------------------------------------------------------------
interface setc_in_if;
	logic               valid;
	logic               ready;
	setc_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/setc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setc_out_if
// Result channel: one result per request with valid/ready.
// ----------------------------------------------------------------------------
interface setc_out_if;
	logic                valid;
	logic                ready;
	setc_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/setc_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface setc_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [setc_pkg::CFG_IDX_BITS-1:0]   index;
	logic [setc_pkg::CFG_DAT_BITS-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/setc_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setc_ring
// Capture ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module setc_ring #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/setc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setc_ctrl
// Trigger detection, holdoff, noise floor, ring pointers and configuration.
// ----------------------------------------------------------------------------
module setc_ctrl #(
	parameter int DEPTH       = 128,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	setc_cfg_if.sink                      cfg,
	input  wire logic                     acc,
	input  wire setc_pkg::in_item_t       item,
	output      logic                     mem_we,
	output      logic [$clog2(DEPTH)-1:0] mem_waddr,
	output      logic [((SAMPLE_BITS < setc_pkg::FIELD_BITS) ? SAMPLE_BITS
	                    : setc_pkg::FIELD_BITS)-1:0] mem_wdata,
	output      logic                     mem_re,
	output      logic [$clog2(DEPTH)-1:0] mem_raddr,
	output      setc_pkg::out_item_t      res,
	output      logic                     rd_ok
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int SW = (SAMPLE_BITS < setc_pkg::FIELD_BITS) ? SAMPLE_BITS
	                    : setc_pkg::FIELD_BITS;
	localparam int CW = (FW > setc_pkg::INDEX_BITS) ? FW : setc_pkg::INDEX_BITS;
	localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
	localparam logic [FW-1:0] FILL_FULL = FW'(DEPTH);

	logic [setc_pkg::LEVEL_BITS-1:0]   level_q;
	logic                              rising_q;
	logic [setc_pkg::HOLDOFF_BITS-1:0] holdoff_q;

	logic [AW-1:0]                     ptr_q;
	logic [FW-1:0]                     fill_q;
	logic [setc_pkg::FIELD_BITS-1:0]   prev_q;
	logic                              first_q;
	logic [setc_pkg::TIME_BITS-1:0]    last_q;
	logic                              captured_q;
	logic [setc_pkg::FIELD_BITS-1:0]   floor_q;

	logic [SW-1:0]                     s_trim;
	logic [setc_pkg::FIELD_BITS-1:0]   s;
	logic [setc_pkg::FIELD_BITS-1:0]   prev_eff;
	logic [setc_pkg::FIELD_BITS-1:0]   floor_eff;
	logic [setc_pkg::TIME_BITS-1:0]    elapsed;
	logic                              armed;
	logic                              hit;
	logic                              fire;
	logic                              is_sample;
	logic [AW-1:0]                     ptr_nx;
	logic [FW-1:0]                     fill_nx;
	logic [setc_pkg::FIELD_BITS-1:0]   floor_nx;

	assign cfg.ready = 1'b1;

	always_comb begin
		is_sample = (item.op == setc_pkg::OP_SAMPLE);
		s_trim    = item.sample[SW-1:0];
		s         = setc_pkg::FIELD_BITS'(s_trim);
		prev_eff  = first_q ? s : prev_q;
		floor_eff = first_q ? s : floor_q;
		elapsed   = item.time_ms - last_q;
		armed     = elapsed > setc_pkg::TIME_BITS'(holdoff_q);
		if (rising_q) begin
			hit = (s > level_q) && (prev_eff <= level_q);
		end else begin
			hit = (s < level_q) && (prev_eff >= level_q);
		end
		fire = hit && armed;

		// ring clear is a rewind of the fill count: entries at or above it read as zero
		if (fire) begin
			ptr_nx  = '0;
			fill_nx = '0;
		end else begin
			ptr_nx  = (ptr_q == PTR_LAST) ? '0 : ptr_q + AW'(1);
			fill_nx = (fill_q == FILL_FULL) ? fill_q : fill_q + FW'(1);
		end

		if (s < floor_eff) begin
			floor_nx = s;
		end else if (floor_eff < level_q) begin
			floor_nx = floor_eff + setc_pkg::FIELD_BITS'(1);
		end else begin
			floor_nx = floor_eff;
		end
	end

	assign mem_we    = acc && is_sample;
	assign mem_waddr = ptr_q;
	assign mem_wdata = s_trim;
	assign mem_re    = acc && !is_sample;
	assign mem_raddr = AW'(item.read_index);

	always_comb begin
		res = '0;
		if (is_sample) begin
			res.trigger_fired = fire;
			res.captured      = captured_q || fire;
			res.write_index   = setc_pkg::INDEX_BITS'(ptr_nx);
			res.floor_level   = floor_nx;
		end else begin
			res.captured      = captured_q;
			res.write_index   = setc_pkg::INDEX_BITS'(ptr_q);
			res.floor_level   = floor_q;
		end
		rd_ok = !is_sample && (CW'(item.read_index) < CW'(fill_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= setc_pkg::LEVEL_RST;
			rising_q  <= setc_pkg::RISING_RST;
			holdoff_q <= setc_pkg::HOLDOFF_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				setc_pkg::CFG_LEVEL:   level_q   <= cfg.data[setc_pkg::LEVEL_BITS-1:0];
				setc_pkg::CFG_RISING:  rising_q  <= cfg.data[0];
				setc_pkg::CFG_HOLDOFF: holdoff_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			fill_q     <= '0;
			prev_q     <= '0;
			first_q    <= 1'b1;
			last_q     <= '0;
			captured_q <= 1'b0;
			floor_q    <= '0;
		end else if (acc && is_sample) begin
			ptr_q   <= ptr_nx;
			fill_q  <= fill_nx;
			prev_q  <= s;
			first_q <= 1'b0;
			floor_q <= floor_nx;
			if (fire) begin
				last_q     <= item.time_ms;
				captured_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/scope_edge_trigger_capture_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scope_edge_trigger_capture_core
// Edge trigger with holdoff over a ring capture buffer for one scope channel.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns its result in the cycle after accept;
// the delay comes from the ring's registered synchronous read, and the
// trigger, holdoff and noise floor update all fit in the accept cycle. While
// a result waits unaccepted the input is held off; a new request is taken in
// the same cycle the waiting result leaves, so a receiver that is always
// ready sees one result per clock. A trigger clears the ring by rewinding a
// fill count, so no clearing pass follows reset or a trigger. Configuration
// writes are always taken.
// ----------------------------------------------------------------------------
module scope_edge_trigger_capture_core #(
	parameter int DEPTH       = 128,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	setc_in_if.sink   item,
	setc_out_if.source result,
	setc_cfg_if.sink  cfg
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = (SAMPLE_BITS < setc_pkg::FIELD_BITS) ? SAMPLE_BITS
	                    : setc_pkg::FIELD_BITS;

	logic                acc;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [SW-1:0]       mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [SW-1:0]       mem_rdata;
	setc_pkg::out_item_t res;
	logic                rd_ok;

	logic                valid_s1;
	setc_pkg::out_item_t res_s1;
	logic                rd_ok_s1;

	assign item.ready = !valid_s1 || result.ready;
	assign acc        = item.valid && item.ready;

	setc_ctrl #(
		.DEPTH       (DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.acc       (acc),
		.item      (item.data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res       (res),
		.rd_ok     (rd_ok)
	);

	setc_ring #(
		.DEPTH (DEPTH),
		.WIDTH (SW)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1   <= res;
			rd_ok_s1 <= rd_ok;
		end
	end

	always_comb begin
		result.data = res_s1;
		result.data.read_value = rd_ok_s1 ? setc_pkg::FIELD_BITS'(mem_rdata) : '0;
	end

	assign result.valid = valid_s1;

endmodule

`default_nettype wire

// ===== verif/scope_edge_trigger_capture_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scope_edge_trigger_capture_core_test
// Self-checking bench for the edge trigger capture core. A built-in model of
// the ring, holdoff and noise floor predicts every result. Requests are
// directed corner cases, a ring wrap, sweeps over trigger settings and a long
// result-side stall, with random gaps on both channels.
// ----------------------------------------------------------------------------
module scope_edge_trigger_capture_core_test;
	import setc_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	setc_in_if  req_ch ();
	setc_out_if res_ch ();
	setc_cfg_if cfg_ch ();

	scope_edge_trigger_capture_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (req_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// capture model state
	logic [FIELD_BITS-1:0]   ring_copy [128];
	logic [INDEX_BITS-1:0]   wr_ptr_m;
	logic [FIELD_BITS-1:0]   prev_m;
	logic                    first_pending_m;
	logic [TIME_BITS-1:0]    last_fire_m;
	logic                    captured_m;
	logic [FIELD_BITS-1:0]   floor_m;
	logic [LEVEL_BITS-1:0]   level_m;
	logic                    rising_m;
	logic [HOLDOFF_BITS-1:0] holdoff_m;

	out_item_t pending_results [$];
	out_item_t want;

	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int rx_stall_left = 0;
	logic [TIME_BITS-1:0] stamp_ms = '0;

	int mismatch_count     = 0;
	int results_checked    = 0;
	int samples_sent       = 0;
	int reads_sent         = 0;
	int triggers_predicted = 0;
	int settings_applied   = 0;

	function automatic out_item_t predict_capture(input in_item_t req);
		out_item_t res;
		logic [TIME_BITS-1:0] elapsed;
		logic hit;
		res = '0;
		if (req.op == OP_SAMPLE) begin
			ring_copy[wr_ptr_m] = req.sample;
			wr_ptr_m = wr_ptr_m + 1'b1;
			if (first_pending_m) begin
				prev_m = req.sample;
				floor_m = req.sample;
				first_pending_m = 1'b0;
			end
			elapsed = req.time_ms - last_fire_m;
			if (rising_m)
				hit = (req.sample > level_m) && (prev_m <= level_m);
			else
				hit = (req.sample < level_m) && (prev_m >= level_m);
			if (hit && (elapsed > {16'd0, holdoff_m})) begin
				last_fire_m = req.time_ms;
				foreach (ring_copy[i])
					ring_copy[i] = '0;
				wr_ptr_m = '0;
				captured_m = 1'b1;
				res.trigger_fired = 1'b1;
				triggers_predicted++;
			end
			prev_m = req.sample;
			if (req.sample < floor_m)
				floor_m = req.sample;
			else if (floor_m < level_m)
				floor_m = floor_m + 1'b1;
		end else begin
			res.read_value = ring_copy[req.read_index];
		end
		res.captured = captured_m;
		res.write_index = wr_ptr_m;
		res.floor_level = floor_m;
		return res;
	endfunction

	// mostly samples near the level so crossings are common; some full-range noise
	function automatic in_item_t random_request();
		in_item_t r;
		int v;
		int pick;
		r.op = ($urandom_range(99) < 20) ? OP_READ : OP_SAMPLE;
		r.read_index = INDEX_BITS'($urandom_range(127));
		pick = $urandom_range(99);
		if (pick < 40)
			v = int'(level_m) + $urandom_range(200);
		else if (pick < 80)
			v = int'(level_m) - 1 - $urandom_range(200);
		else
			v = $urandom_range(4095);
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		r.sample = v[FIELD_BITS-1:0];
		if ($urandom_range(49) == 0)
			stamp_ms = $urandom();
		else
			stamp_ms = stamp_ms + $urandom_range(int'(holdoff_m) / 2 + 20);
		r.time_ms = stamp_ms;
		return r;
	endfunction

	// valid stays high after accept; the next request or a drain decides it
	task automatic send_request(input in_item_t req);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= req;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(predict_capture(req));
		if (req.op == OP_SAMPLE)
			samples_sent++;
		else
			reads_sent++;
	endtask

	task automatic send_sample(input logic [FIELD_BITS-1:0] s, input logic [TIME_BITS-1:0] t);
		in_item_t r;
		r.op = OP_SAMPLE;
		r.sample = s;
		r.time_ms = t;
		r.read_index = INDEX_BITS'($urandom_range(127));
		send_request(r);
	endtask

	task automatic send_read(input logic [INDEX_BITS-1:0] idx);
		in_item_t r;
		r.op = OP_READ;
		r.sample = FIELD_BITS'($urandom_range(4095));
		r.time_ms = $urandom();
		r.read_index = idx;
		send_request(r);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value[CFG_DAT_BITS-1:0];
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			CFG_LEVEL: begin
				level_m = value[LEVEL_BITS-1:0];
			end
			CFG_RISING: begin
				rising_m = value[0];
			end
			CFG_HOLDOFF: begin
				holdoff_m = value[HOLDOFF_BITS-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic apply_setting(input int unsigned lvl, input int unsigned rise,
			input int unsigned hold);
		drain_results();
		write_register(CFG_LEVEL, lvl);
		write_register(CFG_RISING, rise);
		write_register(CFG_HOLDOFF, hold);
		cfg_ch.valid <= 1'b0;
		settings_applied++;
	endtask

	// reset values: level 2109, falling, holdoff 300, last trigger at time 0
	task automatic test_directed();
		send_read(7'd0);
		send_read(7'd127);
		send_sample(12'd4095, 32'd0);          // first sample seeds floor and previous
		send_sample(12'd0, 32'd100);           // crossing too early after reset
		send_sample(12'd4095, 32'd200);
		send_sample(12'd0, 32'd300);           // elapsed equals holdoff, not armed
		send_sample(12'd4095, 32'd301);
		send_sample(12'd2108, 32'd301);        // fires
		send_read(7'd0);
		send_sample(12'd2109, 32'd302);
		send_sample(12'd2109, 32'hFFFF_FFF0);
		send_sample(12'd2108, 32'hFFFF_FFFF);  // fires at the top of time
		send_sample(12'd4095, 32'h0000_0005);
		send_sample(12'd0, 32'h0000_0100);     // wrapped elapsed still inside holdoff
		send_sample(12'd4095, 32'h0000_0200);
		send_sample(12'd0, 32'h0000_012D);     // wrapped elapsed past holdoff
		send_sample(12'd2109, 32'h8000_0000);
		send_read(7'd0);
		send_read(7'd1);
		send_read(7'd2);
		send_read(7'd127);
	endtask

	// hold time at the last trigger so nothing arms, and run the pointer past the end
	task automatic test_ring_wrap();
		repeat (150)
			send_sample(FIELD_BITS'($urandom_range(4095)), last_fire_m);
		repeat (8)
			send_read(INDEX_BITS'($urandom_range(127)));
	endtask

	task automatic test_setting_sweep();
		int unsigned lvl [6]  = '{0, 4095, 2048, 1000, 3000, 0};
		int unsigned rise [6] = '{1, 0, 1, 0, 1, 0};
		int unsigned hold [6] = '{0, 65535, 300, 50, 1000, 0};
		lvl[5]  = $urandom_range(4095);
		rise[5] = $urandom_range(1);
		hold[5] = $urandom_range(65535);
		for (int i = 0; i < 6; i++) begin
			apply_setting(lvl[i], rise[i], hold[i]);
			if (i < 2) begin
				tx_idle_pct = 33;
				rx_idle_pct = 59;
			end else if (i < 4) begin
				tx_idle_pct = 59;
				rx_idle_pct = 33;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			repeat (110)
				send_request(random_request());
		end
	endtask

	// results held back long enough that the core stops taking requests
	task automatic test_result_stall();
		apply_setting(2109, 0, 300);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_stall_left <= 400;
		repeat (40)
			send_request(random_request());
	endtask

	always @(posedge clk) begin
		if (rx_stall_left != 0) begin
			res_ch.ready <= 1'b0;
			rx_stall_left <= rx_stall_left - 1;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("result with no request outstanding: %p", res_ch.data);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.data !== want) begin
					if (mismatch_count < 10)
						$display({"result %0d: expected fired=%0b cap=%0b wr=%0d floor=%0d ",
							"rd=%0d, got fired=%0b cap=%0b wr=%0d floor=%0d rd=%0d"},
							results_checked, want.trigger_fired, want.captured,
							want.write_index, want.floor_level, want.read_value,
							res_ch.data.trigger_fired, res_ch.data.captured,
							res_ch.data.write_index, res_ch.data.floor_level,
							res_ch.data.read_value);
					mismatch_count++;
				end
				results_checked++;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_LEVEL;
		cfg_ch.data  = '0;
		foreach (ring_copy[i])
			ring_copy[i] = '0;
		wr_ptr_m        = '0;
		prev_m          = '0;
		first_pending_m = 1'b1;
		last_fire_m     = '0;
		captured_m      = 1'b0;
		floor_m         = '0;
		level_m         = LEVEL_RST;
		rising_m        = RISING_RST;
		holdoff_m       = HOLDOFF_RST;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 33;
		rx_idle_pct = 59;
		test_directed();
		test_ring_wrap();
		test_setting_sweep();
		test_result_stall();
		drain_results();
		repeat (4)
			@(posedge clk);
		$display("covered %0d samples and %0d reads, %0d triggers, %0d register settings",
			samples_sent, reads_sent, triggers_predicted, settings_applied);
		$display("checked %0d results, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("scope_edge_trigger_capture_core: match");
		else
			$display("scope_edge_trigger_capture_core: mismatch");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("run timed out");
		$display("scope_edge_trigger_capture_core: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/setc_pkg.sv
rtl/core/setc_in_if.sv
rtl/core/setc_out_if.sv
rtl/core/setc_cfg_if.sv
rtl/core/setc_ring.sv
rtl/core/setc_ctrl.sv
rtl/core/scope_edge_trigger_capture_core.sv
verif/scope_edge_trigger_capture_core_test.sv
